FILE: rtl/glyph_text_layout_assert.svh
// Assertion macros for the glyph text layout block.
// Expect clk and rst_n in the scope of every use.
`ifndef GLYPH_TEXT_LAYOUT_ASSERT_SVH
`define GLYPH_TEXT_LAYOUT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define GTL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glyph_text_layout: assertion failed");

// Check cons in the cycle after ante.
`define GTL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glyph_text_layout: assertion failed");

`endif

FILE: rtl/gtl_pkg.sv
// Shared types, widths, codes and fixed-point helpers for the glyph text layout block.
// No dependencies.
package gtl_pkg;

    localparam int CODE_W    = 8;
    localparam int AXY_W     = 12;
    localparam int GSZ_W     = 8;
    localparam int OFF_W     = 8;
    localparam int ADV_W     = 9;
    localparam int POS_W     = 16;
    localparam int SCALE_W   = 12;
    localparam int LH_W      = 8;
    localparam int DSZ_W     = 12;
    localparam int SOFF_W    = 13;
    localparam int SUM_W     = 18;
    localparam int PLACE_W   = 2 * AXY_W;
    localparam int METRICS_W = 2 * GSZ_W + 2 * OFF_W + ADV_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ORIGIN = 2'd1;
    localparam logic [1:0] CMD_CHAR   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_HEIGHT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Q8    = 1'd1;

    localparam logic [CODE_W-1:0]  NEWLINE_CODE     = 8'd10;
    localparam logic [GSZ_W-1:0]   FALLBACK_ADVANCE = 8'd8;
    localparam int                 FALLBACK_DIVISOR = 2;
    localparam logic [SCALE_W-1:0] SCALE_RESET      = 12'd256;

    typedef struct packed {
        logic [1:0]              command;
        logic                    newline;
        logic [POS_W-1:0]        origin_x;
        logic [POS_W-1:0]        origin_y;
        logic                    draw;
        logic [AXY_W-1:0]        src_x;
        logic [AXY_W-1:0]        src_y;
        logic [GSZ_W-1:0]        src_w;
        logic [GSZ_W-1:0]        src_h;
        logic [DSZ_W-1:0]        dst_w;
        logic [DSZ_W-1:0]        dst_h;
        logic signed [SOFF_W-1:0] off_x;
        logic signed [SOFF_W-1:0] off_y;
        logic [DSZ_W-1:0]        step;
        logic [DSZ_W-1:0]        line_step;
    } stage_t;

    // Unsigned magnitude times Q4.8 scale, truncated.
    function automatic logic [DSZ_W-1:0] scale_mag(input logic [GSZ_W-1:0] mag,
                                                  input logic [SCALE_W-1:0] scale);
        logic [GSZ_W+SCALE_W-1:0] prod;
        prod = (GSZ_W+SCALE_W)'(mag) * (GSZ_W+SCALE_W)'(scale);
        return prod[GSZ_W+SCALE_W-1:8];
    endfunction

    // Signed value times scale, truncated toward zero.
    function automatic logic signed [SOFF_W-1:0] scale_signed(input logic [OFF_W-1:0] v,
                                                             input logic [SCALE_W-1:0] scale);
        logic [OFF_W-1:0] mag;
        logic [DSZ_W-1:0] s;
        mag = v[OFF_W-1] ? OFF_W'(-v) : v;
        s   = scale_mag(mag, scale);
        return v[OFF_W-1] ? -signed'({1'b0, s}) : signed'({1'b0, s});
    endfunction

    function automatic logic [POS_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
        if (v > 18'sd32767)
            return 16'h7FFF;
        else if (v < -18'sd32768)
            return 16'h8000;
        else
            return v[POS_W-1:0];
    endfunction

endpackage

FILE: rtl/gtl_in_if.sv
// Input word channel of the glyph text layout block: valid, ready and item fields.
// Depends on gtl_pkg.
interface gtl_in_if
    import gtl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [1:0]          command;
    logic [CODE_W-1:0]   code;
    logic [AXY_W-1:0]    atlas_x;
    logic [AXY_W-1:0]    atlas_y;
    logic [GSZ_W-1:0]    glyph_width;
    logic [GSZ_W-1:0]    glyph_height;
    logic signed [OFF_W-1:0] offset_x;
    logic signed [OFF_W-1:0] offset_y;
    logic signed [ADV_W-1:0] advance;
    logic signed [POS_W-1:0] origin_x;
    logic signed [POS_W-1:0] origin_y;

    modport source (output valid, command, code, atlas_x, atlas_y, glyph_width,
                    glyph_height, offset_x, offset_y, advance, origin_x, origin_y,
                    input ready);
    modport sink (input valid, command, code, atlas_x, atlas_y, glyph_width,
                  glyph_height, offset_x, offset_y, advance, origin_x, origin_y,
                  output ready);
endinterface

FILE: rtl/gtl_out_if.sv
// Result word channel of the glyph text layout block: valid, ready and result fields.
// Depends on gtl_pkg.
interface gtl_out_if
    import gtl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                draw_valid;
    logic [AXY_W-1:0]    src_x;
    logic [AXY_W-1:0]    src_y;
    logic [GSZ_W-1:0]    src_w;
    logic [GSZ_W-1:0]    src_h;
    logic signed [POS_W-1:0] dst_x;
    logic signed [POS_W-1:0] dst_y;
    logic [DSZ_W-1:0]    dst_w;
    logic [DSZ_W-1:0]    dst_h;
    logic signed [POS_W-1:0] pen_after;
    logic [POS_W-1:0]    widest_line;

    modport source (output valid, draw_valid, src_x, src_y, src_w, src_h, dst_x, dst_y,
                    dst_w, dst_h, pen_after, widest_line, input ready);
    modport sink (input valid, draw_valid, src_x, src_y, src_w, src_h, dst_x, dst_y,
                  dst_w, dst_h, pen_after, widest_line, output ready);
endinterface

FILE: rtl/glyph_text_layout.sv
// An accepted item passes table read, scaling and pen update registers in turn to reach its result word.
// Throughput: one item per cycle unless stalled; the pen add and saturate on the pen registers set it.
// A stalled result word holds in the output register while up to two more items wait behind it.
// Reset: glyph table reads as all zero through per-entry fill flags, with no clearing pass;
// pen, line widths and channels clear at once; line_height resets to 0 and scale_q8 to 1.0.
module glyph_text_layout
    import gtl_pkg::*;
#(
    parameter int GLYPH_COUNT = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    gtl_in_if.sink                items,
    gtl_out_if.source             results,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [LH_W-1:0]    line_height_reg, line_height_next;
    logic [SCALE_W-1:0] scale_q8_reg, scale_q8_next;
    logic               stage_valid;
    logic               stage_ready;
    stage_t             stage;

    always_comb
    begin
        line_height_next = line_height_reg;
        scale_q8_next    = scale_q8_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LINE_HEIGHT: line_height_next = cfg_data[LH_W-1:0];
                REG_SCALE_Q8:    scale_q8_next    = cfg_data[SCALE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_height_reg <= '0;
            scale_q8_reg    <= SCALE_RESET;
        end
        else
        begin
            line_height_reg <= line_height_next;
            scale_q8_reg    <= scale_q8_next;
        end
    end

    gtl_lookup #(.GLYPH_COUNT(GLYPH_COUNT)) u_lookup (
        .clk         (clk),
        .rst_n       (rst_n),
        .items       (items),
        .line_height (line_height_reg),
        .scale_q8    (scale_q8_reg),
        .stage_valid (stage_valid),
        .stage       (stage),
        .stage_ready (stage_ready)
    );

    gtl_pen u_pen (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage       (stage),
        .stage_ready (stage_ready),
        .results     (results)
    );

endmodule

FILE: rtl/gtl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gtl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/gtl_lookup.sv
// Glyph table and lookup pipeline: table RAMs, entry valid flags, scaling stage.
// Depends on gtl_pkg, gtl_in_if and gtl_ram.
module gtl_lookup
    import gtl_pkg::*;
#(
    parameter int GLYPH_COUNT = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    gtl_in_if.sink             items,
    input  logic [LH_W-1:0]    line_height,
    input  logic [SCALE_W-1:0] scale_q8,
    output logic               stage_valid,
    output stage_t             stage,
    input  logic               stage_ready
);

    localparam int IDX_W = $clog2(GLYPH_COUNT);

    logic                   accept;
    logic                   in_range;
    logic [IDX_W-1:0]       idx;
    logic                   we;
    logic [PLACE_W-1:0]     place_rd;
    logic [METRICS_W-1:0]   metrics_rd;

    logic [GLYPH_COUNT-1:0] filled_reg, filled_next;
    logic                   s1_valid_reg, s1_valid_next;
    logic [1:0]             s1_cmd_reg;
    logic                   s1_newline_reg;
    logic                   s1_hit_reg;
    logic [POS_W-1:0]       s1_origin_x_reg;
    logic [POS_W-1:0]       s1_origin_y_reg;
    logic                   s1_adv;

    logic                   s2_valid_reg, s2_valid_next;
    stage_t                 s2_reg;
    stage_t                 s2_next;

    logic [PLACE_W-1:0]     place;
    logic [METRICS_W-1:0]   metrics;
    logic [GSZ_W-1:0]       gw, gh;
    logic [OFF_W-1:0]       ox, oy;
    logic [ADV_W-1:0]       adv;
    logic [GSZ_W-1:0]       adv_eff;

    assign accept   = items.valid && items.ready;
    assign in_range = 32'(items.code) < 32'(GLYPH_COUNT);
    assign idx      = items.code[IDX_W-1:0];
    assign we       = accept && (items.command == CMD_LOAD) && in_range;

    gtl_ram #(.WIDTH(PLACE_W), .DEPTH(GLYPH_COUNT)) u_place (
        .clk   (clk),
        .we    (we),
        .waddr (idx),
        .wdata ({items.atlas_y, items.atlas_x}),
        .re    (accept),
        .raddr (idx),
        .rdata (place_rd)
    );

    gtl_ram #(.WIDTH(METRICS_W), .DEPTH(GLYPH_COUNT)) u_metrics (
        .clk   (clk),
        .we    (we),
        .waddr (idx),
        .wdata ({items.advance, items.offset_y, items.offset_x,
                 items.glyph_height, items.glyph_width}),
        .re    (accept),
        .raddr (idx),
        .rdata (metrics_rd)
    );

    // The stage holding the RAM output moves only when the scaled stage is empty or is handing its item on.
    assign s1_adv      = s1_valid_reg && (!s2_valid_reg || stage_ready);
    assign items.ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        filled_next = filled_reg;
        if (we)
        begin
            filled_next[idx] = 1'b1;
        end
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
        if (s1_adv)
            s2_valid_next = 1'b1;
        else if (stage_ready)
            s2_valid_next = 1'b0;
        else
            s2_valid_next = s2_valid_reg;
    end

    // An entry never loaded, or a code past the table, reads as an all-zero glyph.
    always_comb
    begin
        place   = s1_hit_reg ? place_rd : '0;
        metrics = s1_hit_reg ? metrics_rd : '0;
        gw      = metrics[GSZ_W-1:0];
        gh      = metrics[2*GSZ_W-1:GSZ_W];
        ox      = metrics[2*GSZ_W+OFF_W-1:2*GSZ_W];
        oy      = metrics[2*GSZ_W+2*OFF_W-1:2*GSZ_W+OFF_W];
        adv     = metrics[METRICS_W-1:2*GSZ_W+2*OFF_W];
        if (adv[ADV_W-1] || (adv == '0))
            adv_eff = (line_height != '0) ? GSZ_W'(line_height / FALLBACK_DIVISOR)
                                          : FALLBACK_ADVANCE;
        else
            adv_eff = adv[GSZ_W-1:0];

        s2_next.command   = s1_cmd_reg;
        s2_next.newline   = s1_newline_reg;
        s2_next.origin_x  = s1_origin_x_reg;
        s2_next.origin_y  = s1_origin_y_reg;
        s2_next.draw      = (gw != '0) && (gh != '0);
        s2_next.src_x     = place[AXY_W-1:0];
        s2_next.src_y     = place[PLACE_W-1:AXY_W];
        s2_next.src_w     = gw;
        s2_next.src_h     = gh;
        s2_next.dst_w     = scale_mag(gw, scale_q8);
        s2_next.dst_h     = scale_mag(gh, scale_q8);
        s2_next.off_x     = scale_signed(ox, scale_q8);
        s2_next.off_y     = scale_signed(oy, scale_q8);
        s2_next.step      = scale_mag(adv_eff, scale_q8);
        s2_next.line_step = scale_mag(line_height, scale_q8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            filled_reg   <= filled_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg      <= items.command;
            s1_newline_reg  <= (items.code == NEWLINE_CODE);
            s1_hit_reg      <= in_range && filled_reg[idx];
            s1_origin_x_reg <= items.origin_x;
            s1_origin_y_reg <= items.origin_y;
        end
        if (s1_adv)
        begin
            s2_reg <= s2_next;
        end
    end

    assign stage_valid = s2_valid_reg;
    assign stage       = s2_reg;

endmodule

FILE: rtl/gtl_pen.sv
// Pen and line-width state with the result register of the glyph text layout block.
// Depends on gtl_pkg and gtl_out_if.
module gtl_pen
    import gtl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   stage_valid,
    input  stage_t stage,
    output logic   stage_ready,
    gtl_out_if.source results
);

    logic [POS_W-1:0] pen_x_reg, pen_x_next;
    logic [POS_W-1:0] pen_y_reg, pen_y_next;
    logic [POS_W-1:0] start_x_reg, start_x_next;
    logic [POS_W-1:0] line_width_reg, line_width_next;
    logic [POS_W-1:0] max_width_reg, max_width_next;
    logic             out_valid_reg, out_valid_next;

    logic             draw_reg;
    logic [AXY_W-1:0] src_x_reg, src_y_reg;
    logic [GSZ_W-1:0] src_w_reg, src_h_reg;
    logic [POS_W-1:0] dst_x_reg, dst_y_reg;
    logic [DSZ_W-1:0] dst_w_reg, dst_h_reg;
    logic [POS_W-1:0] pen_after_reg;
    logic [POS_W-1:0] widest_reg;

    logic             take;
    logic             draw_now;
    logic [POS_W-1:0] dst_x_sat, dst_y_sat, pen_step_sat, pen_line_sat;
    logic [POS_W:0]   lw_sum;
    logic [POS_W-1:0] lw_sat;
    logic [POS_W-1:0] widest_next;

    assign stage_ready = !out_valid_reg || results.ready;
    assign take        = stage_valid && stage_ready;

    always_comb
    begin
        dst_x_sat    = sat16(SUM_W'(signed'(pen_x_reg)) + SUM_W'(stage.off_x));
        dst_y_sat    = sat16(SUM_W'(signed'(pen_y_reg)) + SUM_W'(stage.off_y));
        pen_step_sat = sat16(SUM_W'(signed'(pen_x_reg)) + SUM_W'(stage.step));
        pen_line_sat = sat16(SUM_W'(signed'(pen_y_reg)) + SUM_W'(stage.line_step));
        lw_sum       = (POS_W+1)'(line_width_reg) + (POS_W+1)'(stage.step);
        lw_sat       = lw_sum[POS_W] ? '1 : lw_sum[POS_W-1:0];

        pen_x_next      = pen_x_reg;
        pen_y_next      = pen_y_reg;
        start_x_next    = start_x_reg;
        line_width_next = line_width_reg;
        max_width_next  = max_width_reg;
        draw_now        = 1'b0;

        case (stage.command)
            CMD_ORIGIN:
            begin
                pen_x_next      = stage.origin_x;
                pen_y_next      = stage.origin_y;
                start_x_next    = stage.origin_x;
                line_width_next = '0;
                max_width_next  = '0;
            end
            CMD_CHAR:
            begin
                if (stage.newline)
                begin
                    // Close the line: fold its width in and drop to the next row.
                    max_width_next  = (line_width_reg > max_width_reg) ? line_width_reg
                                                                       : max_width_reg;
                    line_width_next = '0;
                    pen_x_next      = start_x_reg;
                    pen_y_next      = pen_line_sat;
                end
                else
                begin
                    draw_now        = stage.draw;
                    pen_x_next      = pen_step_sat;
                    line_width_next = lw_sat;
                end
            end
            default:
            begin
            end
        endcase

        widest_next = (line_width_next > max_width_next) ? line_width_next : max_width_next;

        if (take)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            start_x_reg    <= '0;
            line_width_reg <= '0;
            max_width_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                pen_x_reg      <= pen_x_next;
                pen_y_reg      <= pen_y_next;
                start_x_reg    <= start_x_next;
                line_width_reg <= line_width_next;
                max_width_reg  <= max_width_next;
            end
        end
    end

    // Zero the rectangle fields of a word that draws nothing.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            draw_reg      <= draw_now;
            src_x_reg     <= draw_now ? stage.src_x : '0;
            src_y_reg     <= draw_now ? stage.src_y : '0;
            src_w_reg     <= draw_now ? stage.src_w : '0;
            src_h_reg     <= draw_now ? stage.src_h : '0;
            dst_x_reg     <= draw_now ? dst_x_sat : '0;
            dst_y_reg     <= draw_now ? dst_y_sat : '0;
            dst_w_reg     <= draw_now ? stage.dst_w : '0;
            dst_h_reg     <= draw_now ? stage.dst_h : '0;
            pen_after_reg <= pen_x_next;
            widest_reg    <= widest_next;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.draw_valid  = draw_reg;
    assign results.src_x       = src_x_reg;
    assign results.src_y       = src_y_reg;
    assign results.src_w       = src_w_reg;
    assign results.src_h       = src_h_reg;
    assign results.dst_x       = dst_x_reg;
    assign results.dst_y       = dst_y_reg;
    assign results.dst_w       = dst_w_reg;
    assign results.dst_h       = dst_h_reg;
    assign results.pen_after   = pen_after_reg;
    assign results.widest_line = widest_reg;

endmodule

FILE: rtl/gtl_checker.sv
// Port-level checks on the result channel of glyph_text_layout, bound to the top level.
// Depends on gtl_pkg and glyph_text_layout_assert.svh.
`include "glyph_text_layout_assert.svh"

module gtl_checker
    import gtl_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             valid,
    input logic             ready,
    input logic             draw_valid,
    input logic [AXY_W-1:0] src_x,
    input logic [GSZ_W-1:0] src_w,
    input logic [GSZ_W-1:0] src_h,
    input logic [POS_W-1:0] dst_x,
    input logic [DSZ_W-1:0] dst_w,
    input logic [POS_W-1:0] pen_after
);

    logic rect_zero;

    assign rect_zero = (src_x == '0) && (src_w == '0) && (dst_x == '0) && (dst_w == '0);

    `GTL_ASSERT_NEXT(a_valid_holds, valid && !ready, valid)
    `GTL_ASSERT_NEXT(a_word_holds, valid && !ready, $stable(pen_after))
    `GTL_ASSERT_NOW(a_nodraw_zero, valid && !draw_valid, rect_zero)
    `GTL_ASSERT_NOW(a_draw_sized, valid && draw_valid, (src_w != '0) && (src_h != '0))

endmodule

bind glyph_text_layout gtl_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid      (results.valid),
    .ready      (results.ready),
    .draw_valid (results.draw_valid),
    .src_x      (results.src_x),
    .src_w      (results.src_w),
    .src_h      (results.src_h),
    .dst_x      (results.dst_x),
    .dst_w      (results.dst_w),
    .pen_after  (results.pen_after)
);
